@@ sv/fvn_pkg.sv @@
package fvn_pkg;

   localparam int MAX_OCTAVES = 12;
   localparam int QBITS       = 25;
   // stages of the item delay line inside one octave cell
   localparam int CELL_DEPTH  = 8;

   localparam logic [31:0] HASH_K1   = 32'h9E3779B9;
   localparam logic [31:0] HASH_K2   = 32'h85EBCA6B;
   localparam logic [31:0] HASH_K3   = 32'h7FEB352D;
   localparam logic [31:0] HASH_K4   = 32'h846CA68B;
   localparam logic [31:0] SEED_STEP = 32'd1013;
   localparam logic [24:0] ONE24     = 25'h100_0000;
   localparam logic [24:0] HALF24    = 25'h080_0000;
   localparam logic [29:0] AMP_ONE   = 30'd65536;

   typedef enum logic [2:0] {
      REG_SEED    = 3'd0,
      REG_OCTAVES = 3'd1,
      REG_FREQ    = 3'd2,
      REG_PERSIST = 3'd3,
      REG_LACUN   = 3'd4,
      REG_HSCALE  = 3'd5,
      REG_RIDGED  = 3'd6
   } reg_index_type;

   // running state of one item as it moves down the octave chain
   typedef struct packed {
      logic        valid;
      logic [31:0] wx;
      logic [31:0] wz;
      logic [31:0] freq;
      logic [29:0] amp;
      logic [33:0] amp_tot;
      logic [57:0] total;
   } item_type;

endpackage

@@ sv/fvn_cell.sv @@
module fvn_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      seed,
   input  logic             active,
   input  logic             ridged,
   input  logic [19:0]      lacunarity,
   input  logic [16:0]      persistence,
   input  fvn_pkg::item_type item_i,
   output fvn_pkg::item_type item_o
);
   import fvn_pkg::*;

   item_type dly_ff [CELL_DEPTH];
   item_type out_ff;

   logic signed [63:0] px_ff, pz_ff;
   logic [15:0] fx_ff, fz_ff, t2x_ff, t2z_ff;
   logic [31:0] hx0_ff, hx1_ff, hz0_ff, hz1_ff;
   logic [16:0] wx3_ff, wz3_ff, wx4_ff, wz4_ff, wx5_ff, wz5_ff, wx6_ff, wz6_ff, wz7_ff;
   logic [31:0] hv_ff [4];
   logic [31:0] m1_ff [4];
   logic [31:0] m2_ff [4];
   logic [23:0] u_ff [4];
   logic [23:0] lo_ff, hi_ff;
   logic [24:0] smp_ff;

   logic [31:0] cx_in, cz_in;
   logic [31:0] hv_in [4];
   logic [31:0] a_in [4];
   logic [31:0] b_in [4];
   logic [23:0] s_in;
   logic [24:0] smp_in;
   logic [35:0] nf_in;
   item_type    out_in;

   assign cx_in = {{8{px_ff[63]}}, px_ff[63:40]};
   assign cz_in = {{8{pz_ff[63]}}, pz_ff[63:40]};

   // corner c: bit 0 selects x+1, bit 1 selects z+1
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         hv_in[c] = seed ^ (c[0] ? hx1_ff : hx0_ff) ^ (c[1] ? hz1_ff : hz0_ff);
         hv_in[c] = hv_in[c] ^ (hv_in[c] >> 16);
         a_in[c]  = m1_ff[c] ^ (m1_ff[c] >> 15);
         b_in[c]  = m2_ff[c] ^ (m2_ff[c] >> 16);
      end
   end

   always_comb begin
      s_in = 24'((42'(lo_ff) * 42'(17'd65536 - wz7_ff) + 42'(hi_ff) * 42'(wz7_ff)) >> 16);
      // ridged fold 1 - |2s - 1|
      if (!ridged) begin
         smp_in = {1'b0, s_in};
      end else if (s_in[23]) begin
         smp_in = 25'(26'h200_0000 - {1'b0, s_in, 1'b0});
      end else begin
         smp_in = {s_in, 1'b0};
      end
   end

   always_comb begin
      out_in = dly_ff[CELL_DEPTH-1];
      nf_in  = 36'((52'(dly_ff[CELL_DEPTH-1].freq) * 52'(lacunarity)) >> 16);
      if (active) begin
         out_in.total   = dly_ff[CELL_DEPTH-1].total
                        + 58'(55'(smp_ff) * 55'(dly_ff[CELL_DEPTH-1].amp));
         out_in.amp_tot = dly_ff[CELL_DEPTH-1].amp_tot + 34'(dly_ff[CELL_DEPTH-1].amp);
         out_in.amp     = 30'((47'(dly_ff[CELL_DEPTH-1].amp) * 47'(persistence)) >> 16);
         out_in.freq    = (nf_in[35:32] != 4'd0) ? 32'hFFFF_FFFF : nf_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CELL_DEPTH; k++) begin
            dly_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else begin
         dly_ff[0] <= item_i;
         for (int k = 1; k < CELL_DEPTH; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      // scaled coordinate, Q24.40
      px_ff <= 64'($signed(item_i.wx) * $signed({1'b0, item_i.freq}));
      pz_ff <= 64'($signed(item_i.wz) * $signed({1'b0, item_i.freq}));

      fx_ff  <= px_ff[39:24];
      fz_ff  <= pz_ff[39:24];
      t2x_ff <= 16'((32'(px_ff[39:24]) * 32'(px_ff[39:24])) >> 16);
      t2z_ff <= 16'((32'(pz_ff[39:24]) * 32'(pz_ff[39:24])) >> 16);
      hx0_ff <= 32'(cx_in * HASH_K1);
      hx1_ff <= 32'((cx_in + 32'd1) * HASH_K1);
      hz0_ff <= 32'(cz_in * HASH_K2);
      hz1_ff <= 32'((cz_in + 32'd1) * HASH_K2);

      wx3_ff <= 17'((34'(t2x_ff) * 34'(18'd196608 - {1'b0, fx_ff, 1'b0})) >> 16);
      wz3_ff <= 17'((34'(t2z_ff) * 34'(18'd196608 - {1'b0, fz_ff, 1'b0})) >> 16);
      for (int c = 0; c < 4; c++) begin
         hv_ff[c] <= hv_in[c];
         m1_ff[c] <= 32'(hv_ff[c] * HASH_K3);
         m2_ff[c] <= 32'(a_in[c] * HASH_K4);
         u_ff[c]  <= b_in[c][23:0];
      end
      wx4_ff <= wx3_ff;
      wz4_ff <= wz3_ff;
      wx5_ff <= wx4_ff;
      wz5_ff <= wz4_ff;
      wx6_ff <= wx5_ff;
      wz6_ff <= wz5_ff;

      lo_ff  <= 24'((42'(u_ff[0]) * 42'(17'd65536 - wx6_ff) + 42'(u_ff[1]) * 42'(wx6_ff)) >> 16);
      hi_ff  <= 24'((42'(u_ff[2]) * 42'(17'd65536 - wx6_ff) + 42'(u_ff[3]) * 42'(wx6_ff)) >> 16);
      wz7_ff <= wz6_ff;

      smp_ff <= smp_in;
   end

   assign item_o = out_ff;

endmodule

@@ sv/fvn_div.sv @@
module fvn_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [57:0]               dividend,
   input  logic [33:0]               divisor,
   output logic                      out_valid,
   output logic [fvn_pkg::QBITS-1:0] quotient,
   output logic                      div_zero
);
   import fvn_pkg::*;

   // one quotient bit per stage, MSB first
   logic             v_ff [QBITS];
   logic             z_ff [QBITS];
   logic [57:0]      r_ff [QBITS];
   logic [33:0]      d_ff [QBITS];
   logic [QBITS-1:0] q_ff [QBITS];

   for (genvar j = 0; j < QBITS; j++) begin : g_stage
      logic             v_src, z_src, ge_in;
      logic [57:0]      r_src, sh_in;
      logic [33:0]      d_src;
      logic [QBITS-1:0] q_src;

      if (j == 0) begin : g_first
         assign v_src = in_valid;
         assign z_src = (divisor == 34'd0);
         assign r_src = dividend;
         assign d_src = divisor;
         assign q_src = '0;
      end else begin : g_next
         assign v_src = v_ff[j-1];
         assign z_src = z_ff[j-1];
         assign r_src = r_ff[j-1];
         assign d_src = d_ff[j-1];
         assign q_src = q_ff[j-1];
      end

      assign sh_in = {24'd0, d_src} << (QBITS - 1 - j);
      assign ge_in = (r_src >= sh_in);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         z_ff[j] <= z_src;
         d_ff[j] <= d_src;
         r_ff[j] <= ge_in ? r_src - sh_in : r_src;
         q_ff[j] <= {q_src[QBITS-2:0], ge_in};
      end
   end

   assign out_valid = v_ff[QBITS-1];
   assign quotient  = q_ff[QBITS-1];
   assign div_zero  = z_ff[QBITS-1];

endmodule

@@ sv/fractal_value_noise_height.sv @@
// Fractal value-noise height: one world (x, z) pair in, one Q16.16 height out.
// Fully pipelined: start is taken in every cycle (busy is always low) and each
// height appears on rsp_valid/rsp_height in order, for one cycle; there is no
// backpressure, so the receiver must take it then. The pipeline is a chain of
// twelve octave cells of nine stages each, a 25-stage restoring divider for
// the amplitude normalization and two output stages. Registers must only be
// written while no item is in flight.
module fractal_value_noise_height (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_world_x,
   input  logic [31:0] req_world_z,
   output logic        rsp_valid,
   output logic [31:0] rsp_height,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fvn_pkg::*;

   logic [31:0] seed_ff, freq_ff, hscale_ff;
   logic [3:0]  octaves_ff, count_in;
   logic [16:0] persist_ff;
   logic [19:0] lacun_ff;
   logic        ridged_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= 32'd0;
         octaves_ff <= 4'd4;
         freq_ff    <= 32'd167772;
         persist_ff <= 17'd32768;
         lacun_ff   <= 20'd131072;
         hscale_ff  <= 32'd65536;
         ridged_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SEED:    seed_ff    <= csr_wdata;
            REG_OCTAVES: octaves_ff <= csr_wdata[3:0];
            REG_FREQ:    freq_ff    <= csr_wdata;
            REG_PERSIST: persist_ff <= csr_wdata[16:0];
            REG_LACUN:   lacun_ff   <= csr_wdata[19:0];
            REG_HSCALE:  hscale_ff  <= csr_wdata;
            REG_RIDGED:  ridged_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign count_in = (octaves_ff > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octaves_ff;
   assign busy     = 1'b0;

   item_type chain [MAX_OCTAVES+1];

   assign chain[0] = '{valid:   start,
                       wx:      req_world_x,
                       wz:      req_world_z,
                       freq:    freq_ff,
                       amp:     AMP_ONE,
                       amp_tot: 34'd0,
                       total:   58'd0};

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      logic [31:0] cell_seed;
      logic        cell_active;

      assign cell_seed   = seed_ff + 32'(k * SEED_STEP);
      assign cell_active = (4'(k) < count_in);

      fvn_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .seed        (cell_seed),
         .active      (cell_active),
         .ridged      (ridged_ff),
         .lacunarity  (lacun_ff),
         .persistence (persist_ff),
         .item_i      (chain[k]),
         .item_o      (chain[k+1])
      );
   end

   logic             dv_out, dz_out;
   logic [QBITS-1:0] dq_out;

   fvn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain[MAX_OCTAVES].valid),
      .dividend  (chain[MAX_OCTAVES].total),
      .divisor   (chain[MAX_OCTAVES].amp_tot),
      .out_valid (dv_out),
      .quotient  (dq_out),
      .div_zero  (dz_out)
   );

   logic [24:0]        norm_in;
   logic signed [26:0] m_in;
   logic signed [59:0] prod_ff;
   logic signed [35:0] h_in;
   logic               pv_ff, rv_ff;
   logic [31:0]        height_ff;

   assign norm_in = dz_out ? HALF24 : dq_out;
   assign m_in    = $signed(27'({1'b0, norm_in, 1'b0}) - 27'(ONE24));
   // floor division by 2^24
   assign h_in    = 36'(prod_ff >>> 24);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         pv_ff <= dv_out;
         rv_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 60'(m_in * $signed({1'b0, hscale_ff}));
      if (h_in > 36'sh0_7FFF_FFFF) begin
         height_ff <= 32'h7FFF_FFFF;
      end else if (h_in < -36'sh0_8000_0000) begin
         height_ff <= 32'h8000_0000;
      end else begin
         height_ff <= h_in[31:0];
      end
   end

   assign rsp_valid  = rv_ff;
   assign rsp_height = height_ff;

endmodule

@@ verif/fractal_value_noise_height_tb.sv @@
module fractal_value_noise_height_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fvn_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int LATENCY = 135;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_world_x = '0;
   logic [31:0] req_world_z = '0;
   logic        rsp_valid;
   logic [31:0] rsp_height;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow copy of the register file
   logic [31:0] seed_r;
   logic [3:0]  octaves_r;
   logic [31:0] freq_r;
   logic [16:0] persist_r;
   logic [19:0] lacun_r;
   logic [31:0] hscale_r;
   logic        ridged_r;

   logic [31:0] heights_due[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          idle_pct = 0;

   fractal_value_noise_height i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_world_x(req_world_x), .req_world_z(req_world_z),
      .rsp_valid(rsp_valid), .rsp_height(rsp_height),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] lattice_hash(logic [31:0] lx, logic [31:0] lz,
                                                logic [31:0] sd);
      logic [31:0] v;
      v = sd ^ (lx * HASH_K1);
      v = v ^ (lz * HASH_K2);
      v = v ^ (v >> 16);
      v = v * HASH_K3;
      v = v ^ (v >> 15);
      v = v * HASH_K4;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic logic [63:0] smooth(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t) >> 16;
      return (t2 * (64'd196608 - 2 * t)) >> 16;
   endfunction

   function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] w);
      return (a * (64'd65536 - w) + b * w) >> 16;
   endfunction

   function automatic logic [63:0] octave_value(logic [31:0] x, logic [31:0] z,
                                                logic [31:0] f, logic [31:0] sd);
      longint      px, pz;
      logic [31:0] cx, cz;
      logic [63:0] tx, tz, c00, c10, c01, c11;
      px = longint'($signed(x)) * longint'({32'b0, f});
      pz = longint'($signed(z)) * longint'({32'b0, f});
      cx = {{8{px[63]}}, px[63:40]};
      cz = {{8{pz[63]}}, pz[63:40]};
      tx = smooth({48'b0, px[39:24]});
      tz = smooth({48'b0, pz[39:24]});
      c00 = {40'b0, lattice_hash(cx, cz, sd) & 32'h00FF_FFFF};
      c10 = {40'b0, lattice_hash(cx + 1, cz, sd) & 32'h00FF_FFFF};
      c01 = {40'b0, lattice_hash(cx, cz + 1, sd) & 32'h00FF_FFFF};
      c11 = {40'b0, lattice_hash(cx + 1, cz + 1, sd) & 32'h00FF_FFFF};
      return lerp(lerp(c00, c10, tx), lerp(c01, c11, tx), tz);
   endfunction

   function automatic logic [31:0] terrain_height(logic [31:0] x, logic [31:0] z);
      int          count;
      logic [63:0] amp, amp_sum, acc, s, nf;
      logic [31:0] f;
      longint      d, norm, m, prod, h;
      count = (octaves_r > MAX_OCTAVES) ? MAX_OCTAVES : octaves_r;
      amp = 64'd65536;
      amp_sum = '0;
      acc = '0;
      f = freq_r;
      for (int o = 0; o < count; o++) begin
         s = octave_value(x, z, f, seed_r + o * SEED_STEP);
         if (ridged_r) begin
            d = 2 * longint'(s) - (longint'(1) << 24);
            if (d < 0) d = -d;
            s = 64'((longint'(1) << 24) - d);
         end
         acc += s * amp;
         amp_sum += amp;
         amp = (amp * {47'b0, persist_r}) >> 16;
         nf = ({32'b0, f} * {44'b0, lacun_r}) >> 16;
         f = (nf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nf[31:0];
      end
      norm = (amp_sum != 0) ? longint'(acc / amp_sum) : (longint'(1) << 23);
      m = 2 * norm - (longint'(1) << 24);
      prod = m * longint'({32'b0, hscale_r});
      h = prod >>> 24;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fractal_value_noise_height: mismatch");
         $finish;
      end
   end

   // results cannot be held off: check every strobe at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (heights_due.size() == 0) begin
            $display("%0t: unexpected height, actual %h", $time, rsp_height);
            fail_count++;
         end else begin
            if (rsp_height !== heights_due[0]) begin
               $display("%0t: height expected %h actual %h", $time, heights_due[0],
                        rsp_height);
               fail_count++;
            end
            void'(heights_due.pop_front());
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         REG_SEED:    seed_r = v;
         REG_OCTAVES: octaves_r = v[3:0];
         REG_FREQ:    freq_r = v;
         REG_PERSIST: persist_r = v[16:0];
         REG_LACUN:   lacun_r = v[19:0];
         REG_HSCALE:  hscale_r = v;
         REG_RIDGED:  ridged_r = v[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] sd, logic [31:0] oc, logic [31:0] f,
                            logic [31:0] p, logic [31:0] l, logic [31:0] hs,
                            logic [31:0] rg);
      write_reg(REG_SEED, sd);
      write_reg(REG_OCTAVES, oc);
      write_reg(REG_FREQ, f);
      write_reg(REG_PERSIST, p);
      write_reg(REG_LACUN, l);
      write_reg(REG_HSCALE, hs);
      write_reg(REG_RIDGED, rg);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic idle_cycle();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_coord(logic [31:0] x, logic [31:0] z);
      // each cycle is idle with probability idle_pct
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) idle_cycle();
      start <= 1'b1;
      req_world_x <= x;
      req_world_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      heights_due = {heights_due, terrain_height(x, z)};
   endtask

   task automatic drain();
      idle_cycle();
      while (heights_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_defaults();
      send_coord(32'h0000_0000, 32'h0000_0000);
      send_coord(32'h7FFF_FFFF, 32'h8000_0000);
      send_coord(32'h8000_0000, 32'h7FFF_FFFF);
      send_coord(32'hFFFF_FFFF, 32'h0001_0000);
      send_coord(32'h0000_8000, 32'hFFFF_8000);
      drain();
   endtask

   task automatic test_octave_counts();
      // zero octaves gives flat ground; 13..15 clamp to the maximum
      configure(32'h1234_5678, 0, 32'd167772, 32'd32768, 32'd131072, 32'd65536, 0);
      send_coord(32'h0003_2000, 32'hFFF1_0000);
      drain();
      configure(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'd65536, 32'd65536, 32'hFFFF_FFFF, 1);
      send_coord(32'h0001_1111, 32'h0002_2222);
      send_coord(32'h8000_0000, 32'h8000_0000);
      drain();
      configure(32'd77, 15, 32'h0100_0000, 32'h1FFFF, 32'hFFFFF, 32'hFFFF_FFFF, 0);
      send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_coord(32'h0000_1234, 32'hFFFF_0001);
      drain();
      configure(32'd5, 12, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1);
      // an index past the register list is ignored
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      csr_we <= 1'b0;
      send_coord(32'h1234_5678, 32'h8765_4321);
      drain();
      configure(32'd9, 13, 32'h0400_0000, 32'd0, 32'd131072, 32'd0, 0);
      send_coord(32'h0000_4000, 32'h0000_C000);
      drain();
      configure(32'd3, 12, 32'h0000_0001, 32'd65536, 32'hFFFFF, 32'h8000_0000, 0);
      send_coord(32'h7FFF_FFFF, 32'h8000_0001);
      send_coord(32'h0000_0001, 32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_random(int n, int pct);
      configure($urandom, $urandom_range(1, 12),
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h0100_0000),
                $urandom_range(0, 65536), $urandom_range(65536, 1048575),
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000),
                $urandom_range(1));
      idle_pct = pct;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) send_coord($urandom, $urandom);
         else send_coord($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                         $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
      end
      idle_pct = 0;
      drain();
   endtask

   initial begin
      seed_r = 0; octaves_r = 4; freq_r = 32'd167772; persist_r = 17'd32768;
      lacun_r = 20'd131072; hscale_r = 32'd65536; ridged_r = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_octave_counts();
      test_random(160, 0);
      test_random(160, 54);
      test_random(160, 17);
      test_random(150, 0);
      test_random(150, 54);
      test_random(150, 17);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("fractal_value_noise_height: match");
      end else begin
         $display("fractal_value_noise_height: mismatch");
      end
      $finish;
   end
endmodule
